/* hdl/slqe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slqe_pkg: shared constants for the scope line quad expander
// Segment count, divider widths and register map.
// ----------------------------------------------------------------------------
package slqe_pkg;

    localparam int SEGMENTS = 256;
    localparam int SEG_W    = $clog2(SEGMENTS + 1);

    // serial divider: dividend / quotient width, divisor width
    localparam int DIV_NW = 38;
    localparam int DIV_DW = 25;

    localparam int CFG_N   = 8;
    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_ROT_X_XT = 3'd0;
    localparam logic [2:0] REG_ROT_X_YT = 3'd1;
    localparam logic [2:0] REG_ROT_Y_XT = 3'd2;
    localparam logic [2:0] REG_ROT_Y_YT = 3'd3;
    localparam logic [2:0] REG_ROT_Z_XT = 3'd4;
    localparam logic [2:0] REG_ROT_Z_YT = 3'd5;
    localparam logic [2:0] REG_HW_X     = 3'd6;
    localparam logic [2:0] REG_HW_Y     = 3'd7;

endpackage
`default_nettype wire

/* hdl/slqe_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slqe_div: serial unsigned divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module slqe_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [slqe_pkg::DIV_NW-1:0]   i_dividend,
    input  logic [slqe_pkg::DIV_DW-1:0]   i_divisor,
    output logic                          o_done,
    output logic [slqe_pkg::DIV_NW-1:0]   o_quot
);
    import slqe_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DIV_DW:0]   r_rem, n_rem;
    logic [DIV_NW-1:0] r_quo, n_quo;
    logic [DIV_DW-1:0] r_div, n_div;
    logic [DIV_DW:0]   w_sh;

    always_comb begin
        w_sh   = {r_rem[DIV_DW-1:0], r_quo[DIV_NW-1]};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_div}) begin
                n_rem = w_sh - {1'b0, r_div};
                n_quo = {r_quo[DIV_NW-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[DIV_NW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(DIV_NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

/* hdl/scope_line_quad_expander.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scope_line_quad_expander: audio samples to thick polyline quad vertices
// Compresses, places, rotates and projects each sample; every point after a
// line start emits the eight vertices of the quad joining it to the last one.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_in_valid / o_in_ready) takes one sample beat at a time.
//  Output channel (o_out_valid / i_out_ready) gives eight vertex beats per
//  segment; a line-start beat gives none.
//  One beat is worked on at a time. The work on a segment beat is set by
//  the 16-round log2 loop, the 25-step square root and five passes of the
//  bit-serial divider, plus its eight output beats; a line-start beat needs
//  the log2 loop and two of the divider passes.
//  The output register holds one vertex; when the receiver stalls the
//  sequencer waits on it, and the next input beat is taken once the eighth
//  vertex sits in the output register.
//  Reset (synchronous, active low) loads the register defaults, clears the
//  previous point, segment count and open-line flag, and drops o_out_valid.
//  The user must write registers over the APB port only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module scope_line_quad_expander (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [15:0]            i_sample,
    input  logic                          i_line_start,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [15:0]            o_vert_x,
    output logic signed [15:0]            o_vert_y,
    output logic [2:0]                    o_corner,
    output logic [7:0]                    o_segment,
    output logic                          o_last,
    output logic                          o_zero_length,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slqe_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import slqe_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_LOG  = 11'b00000000010,
        S_YT   = 11'b00000000100,
        S_MAC  = 11'b00000001000,
        S_DEN  = 11'b00000010000,
        S_PDIV = 11'b00000100000,
        S_SQ   = 11'b00001000000,
        S_SQRT = 11'b00010000000,
        S_OMUL = 11'b00100000000,
        S_ODIV = 11'b01000000000,
        S_EMIT = 11'b10000000000
    } t_state;

    function automatic logic signed [15:0] sat_mag(input logic neg,
                                                   input logic [DIV_NW-1:0] q);
        logic signed [15:0] v;
        if (neg) begin
            v = (q > DIV_NW'(32768)) ? -16'sd32768 : $signed(16'(~q[15:0] + 16'd1));
        end else begin
            v = (q > DIV_NW'(32767)) ? 16'sd32767 : $signed(q[15:0]);
        end
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
        logic signed [15:0] r;
        if (v > 26'sd32767) begin
            r = 16'sd32767;
        end else if (v < -26'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // control state
    t_state             r_state, n_state;
    logic [4:0]         r_cnt, n_cnt;
    logic               r_line_open, n_line_open;
    logic [SEG_W-1:0]   r_seg, n_seg;
    logic signed [15:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic               r_out_valid, n_out_valid;
    logic               r_div_start, n_div_start;
    logic [15:0]        r_cfg [CFG_N];

    // datapath
    logic signed [15:0] r_sample, n_sample;
    logic               r_start, n_start;
    logic [30:0]        r_m, n_m;
    logic [17:0]        r_lg, n_lg;
    logic signed [15:0] r_yt, n_yt;
    logic signed [35:0] r_acc, n_acc;
    logic signed [17:0] r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic [DIV_DW-1:0]  r_dv, n_dv;
    logic [DIV_NW-1:0]  r_dividend, n_dividend;
    logic [DIV_DW-1:0]  r_divisor, n_divisor;
    logic signed [15:0] r_cx, n_cx, r_cy, n_cy;
    logic [49:0]        r_v, n_v, r_r, n_r;
    logic               r_neg, n_neg;
    logic signed [23:0] r_tx, n_tx, r_ty, n_ty, r_ny, n_ny;
    logic               r_zl, n_zl;
    logic signed [15:0] r_ox, n_ox, r_oy, n_oy;
    logic [2:0]         r_ocorner, n_ocorner;
    logic [7:0]         r_oseg, n_oseg;
    logic               r_olast, n_olast, r_ozl, n_ozl;

    // combinational
    logic               w_accept, w_load;
    logic signed [16:0] w_s17;
    logic [16:0]        w_mag;
    logic [17:0]        w_a;
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;
    logic signed [15:0] w_kn;
    logic [15:0]        w_kabs;
    logic [27:0]        w_xm, w_xq;
    logic signed [15:0] w_xt;
    logic [31:0]        w_q32;
    logic [14:0]        w_ytm;
    logic signed [35:0] w_sum;
    logic [35:0]        w_sabs;
    logic [17:0]        w_rq;
    logic signed [17:0] w_rnd;
    logic signed [18:0] w_den;
    logic [DIV_DW-1:0]  w_dv, w_dvsel;
    logic signed [17:0] w_psrc;
    logic [17:0]        w_pabs;
    logic               w_div_done;
    logic [DIV_NW-1:0]  w_quot;
    logic signed [15:0] w_qs;
    logic signed [16:0] w_dx, w_dy;
    logic [49:0]        w_bit, w_t;
    logic signed [33:0] w_pr34;
    logic [32:0]        w_oabs;
    logic signed [23:0] w_oq, w_oval;
    logic [2:0]         w_i;
    logic signed [15:0] w_bx, w_by;
    logic signed [25:0] w_tsx, w_tsy, w_ex, w_ey;
    logic signed [15:0] w_coef;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign pready     = 1'b1;

    always_comb begin
        unique case (paddr[4:2])
            REG_ROT_X_XT: prdata = 32'($signed(r_cfg[REG_ROT_X_XT]));
            REG_ROT_X_YT: prdata = 32'($signed(r_cfg[REG_ROT_X_YT]));
            REG_ROT_Y_XT: prdata = 32'($signed(r_cfg[REG_ROT_Y_XT]));
            REG_ROT_Y_YT: prdata = 32'($signed(r_cfg[REG_ROT_Y_YT]));
            REG_ROT_Z_XT: prdata = 32'($signed(r_cfg[REG_ROT_Z_XT]));
            REG_ROT_Z_YT: prdata = 32'($signed(r_cfg[REG_ROT_Z_YT]));
            REG_HW_X:     prdata = {16'd0, r_cfg[REG_HW_X]};
            default:      prdata = {16'd0, r_cfg[REG_HW_Y]};
        endcase
    end

    always_comb begin
        unique case (r_cnt[2:0])
            REG_ROT_X_XT: w_coef = $signed(r_cfg[REG_ROT_X_XT]);
            REG_ROT_X_YT: w_coef = $signed(r_cfg[REG_ROT_X_YT]);
            REG_ROT_Y_XT: w_coef = $signed(r_cfg[REG_ROT_Y_XT]);
            REG_ROT_Y_YT: w_coef = $signed(r_cfg[REG_ROT_Y_YT]);
            REG_ROT_Z_XT: w_coef = $signed(r_cfg[REG_ROT_Z_XT]);
            default:      w_coef = $signed(r_cfg[REG_ROT_Z_YT]);
        endcase
    end

    // sample magnitude and log2 normalization
    assign w_s17 = 17'(i_sample);
    assign w_mag = (w_s17 < 0) ? 17'(-w_s17) : 17'(w_s17);
    assign w_a   = 18'({w_mag, 1'b0}) + 18'(w_mag) + 18'd32768;

    // line position
    assign w_kn   = $signed(16'({r_seg, 1'b0})) + 16'sd2 - 16'(SEGMENTS);
    assign w_kabs = (w_kn < 0) ? 16'(-w_kn) : 16'(w_kn);
    assign w_xm   = {w_kabs[13:0], 14'd0};
    assign w_xq   = 28'((w_xm + 28'(SEGMENTS / 2)) / 28'(SEGMENTS));
    assign w_xt   = r_start ? -16'sd16384
                  : ((w_kn < 0) ? -$signed(w_xq[15:0]) : $signed(w_xq[15:0]));

    assign w_dx = 17'(r_cx) - 17'(r_prev_x);
    assign w_dy = 17'(r_cy) - 17'(r_prev_y);

    // shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_LOG: begin
                w_ma = $signed({1'b0, r_m});
                w_mb = $signed({1'b0, r_m});
            end
            S_YT: begin
                w_ma = $signed({16'd0, r_lg[17:2]});
                w_mb = 32'sd13107;
            end
            S_MAC: begin
                w_ma = 32'(w_coef);
                w_mb = r_cnt[0] ? 32'(r_yt) : 32'(w_xt);
            end
            S_SQ: begin
                w_ma = r_cnt[0] ? 32'(w_dy) : 32'(w_dx);
                w_mb = r_cnt[0] ? 32'(w_dy) : 32'(w_dx);
            end
            S_OMUL: begin
                w_ma = (r_cnt[1:0] == 2'd1) ? 32'(w_dy) : 32'(w_dx);
                w_mb = (r_cnt[1:0] == 2'd2) ? $signed({16'd0, r_cfg[REG_HW_Y]})
                                           : $signed({16'd0, r_cfg[REG_HW_X]});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    assign w_q32  = w_prod[61:30];
    assign w_ytm  = 15'((w_prod[31:0] + 32'd32768) >> 16);
    assign w_sum  = r_acc + w_prod[35:0];
    assign w_sabs = (w_sum < 0) ? 36'(-w_sum) : 36'(w_sum);
    assign w_rq   = 18'((w_sabs + 36'd8192) >> 14);
    assign w_rnd  = (w_sum < 0) ? -$signed(w_rq) : $signed(w_rq);

    // projection
    assign w_den   = (19'(r_pz) + 19'sd65536 < 19'sd1) ? 19'sd1 : 19'(r_pz) + 19'sd65536;
    assign w_dv    = DIV_DW'({w_den, 1'b0}) + DIV_DW'(w_den);
    assign w_dvsel = (r_state == S_DEN) ? w_dv : r_dv;
    assign w_psrc  = (r_state == S_DEN) ? r_px : r_py;
    assign w_pabs  = (w_psrc < 0) ? 18'(-w_psrc) : 18'(w_psrc);
    assign w_qs    = sat_mag(r_cnt[0] ? (r_py < 0) : (r_px < 0), w_quot);

    // square root step
    assign w_bit = 50'd1 << {r_cnt, 1'b0};
    assign w_t   = r_r + w_bit;

    // offsets
    assign w_pr34 = w_prod[33:0];
    assign w_oabs = (w_pr34 < 0) ? 33'(-w_pr34) : 33'(w_pr34);
    assign w_oq   = $signed({1'b0, w_quot[22:0]});
    assign w_oval = r_neg ? -w_oq : w_oq;

    // vertex assembly
    assign w_i   = r_cnt[2:0];
    assign w_bx  = w_i[2] ? r_cx : r_prev_x;
    assign w_by  = w_i[2] ? r_cy : r_prev_y;
    assign w_tsx = (w_i[2:1] == 2'd0) ? -26'(r_tx) : ((w_i[2:1] == 2'd3) ? 26'(r_tx) : '0);
    assign w_tsy = (w_i[2:1] == 2'd0) ? -26'(r_ty) : ((w_i[2:1] == 2'd3) ? 26'(r_ty) : '0);
    assign w_ex  = 26'(w_bx) + (w_i[0] ? -26'(r_ty) : 26'(r_ty)) + w_tsx;
    assign w_ey  = 26'(w_by) + (w_i[0] ? 26'(r_ny) : -26'(r_ny)) + w_tsy;
    assign w_load = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_line_open = r_line_open;
        n_seg       = r_seg;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_out_valid = r_out_valid && !i_out_ready;
        n_div_start = 1'b0;
        n_sample    = r_sample;
        n_start     = r_start;
        n_m         = r_m;
        n_lg        = r_lg;
        n_yt        = r_yt;
        n_acc       = r_acc;
        n_px        = r_px;
        n_py        = r_py;
        n_pz        = r_pz;
        n_dv        = r_dv;
        n_dividend  = r_dividend;
        n_divisor   = r_divisor;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_v         = r_v;
        n_r         = r_r;
        n_neg       = r_neg;
        n_tx        = r_tx;
        n_ty        = r_ty;
        n_ny        = r_ny;
        n_zl        = r_zl;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_ocorner   = r_ocorner;
        n_oseg      = r_oseg;
        n_olast     = r_olast;
        n_ozl       = r_ozl;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_sample = i_sample;
                    n_start  = i_line_start || !r_line_open;
                    n_cnt    = '0;
                    if (w_a[17]) begin
                        n_m  = 31'({w_a, 13'd0});
                        n_lg = 18'h20000;
                    end else if (w_a[16]) begin
                        n_m  = {w_a[16:0], 14'd0};
                        n_lg = 18'h10000;
                    end else begin
                        n_m  = {w_a[15:0], 15'd0};
                        n_lg = 18'h00000;
                    end
                    n_state = S_LOG;
                end
            end
            S_LOG: begin
                if (w_q32[31]) begin
                    n_m = w_q32[31:1];
                    n_lg[4'd15 - r_cnt[3:0]] = 1'b1;
                end else begin
                    n_m = w_q32[30:0];
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    n_cnt   = '0;
                    n_state = S_YT;
                end
            end
            S_YT: begin
                n_yt    = r_sample[15] ? -$signed({1'b0, w_ytm}) : $signed({1'b0, w_ytm});
                n_cnt   = '0;
                n_state = S_MAC;
            end
            S_MAC: begin
                if (!r_cnt[0]) begin
                    n_acc = w_prod[35:0];
                end else begin
                    unique case (r_cnt[2:1])
                        2'd0:    n_px = w_rnd;
                        2'd1:    n_py = w_rnd;
                        default: n_pz = w_rnd;
                    endcase
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd5) begin
                    n_state = S_DEN;
                end
            end
            S_DEN: begin
                n_dv        = w_dv;
                n_divisor   = w_dv;
                n_dividend  = DIV_NW'({w_pabs, 15'd0}) + DIV_NW'(w_dvsel >> 1);
                n_div_start = 1'b1;
                n_cnt       = '0;
                n_state     = S_PDIV;
            end
            S_PDIV: begin
                if (w_div_done) begin
                    if (!r_cnt[0]) begin
                        n_cx        = w_qs;
                        n_dividend  = DIV_NW'({w_pabs, 15'd0}) + DIV_NW'(w_dvsel >> 1);
                        n_div_start = 1'b1;
                        n_cnt       = 5'd1;
                    end else if (r_start) begin
                        n_prev_x    = r_cx;
                        n_prev_y    = w_qs;
                        n_seg       = '0;
                        n_line_open = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_cy    = w_qs;
                        n_cnt   = '0;
                        n_state = S_SQ;
                    end
                end
            end
            S_SQ: begin
                if (!r_cnt[0]) begin
                    n_acc = w_prod[35:0];
                    n_cnt = 5'd1;
                end else if (w_sum == 0) begin
                    n_zl    = 1'b1;
                    n_tx    = '0;
                    n_ty    = '0;
                    n_ny    = '0;
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_zl    = 1'b0;
                    n_v     = {w_sum[33:0], 16'd0};
                    n_r     = '0;
                    n_cnt   = 5'd24;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_v >= w_t) begin
                    n_v = r_v - w_t;
                    n_r = (r_r >> 1) + w_bit;
                end else begin
                    n_r = r_r >> 1;
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_cnt   = '0;
                    n_state = S_OMUL;
                end
            end
            S_OMUL: begin
                n_neg       = w_pr34 < 0;
                n_divisor   = r_r[DIV_DW-1:0];
                n_dividend  = DIV_NW'({w_oabs, 5'd0}) + DIV_NW'(r_r[DIV_DW-1:1]);
                n_div_start = 1'b1;
                n_state     = S_ODIV;
            end
            S_ODIV: begin
                if (w_div_done) begin
                    unique case (r_cnt[1:0])
                        2'd0:    n_tx = w_oval;
                        2'd1:    n_ty = w_oval;
                        default: n_ny = w_oval;
                    endcase
                    if (r_cnt == 5'd2) begin
                        n_cnt   = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_cnt   = r_cnt + 5'd1;
                        n_state = S_OMUL;
                    end
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_ox        = sat16(w_ex);
                    n_oy        = sat16(w_ey);
                    n_ocorner   = w_i;
                    n_oseg      = 8'(r_seg);
                    n_olast     = (w_i == 3'd7);
                    n_ozl       = r_zl;
                    n_cnt       = r_cnt + 5'd1;
                    if (w_i == 3'd7) begin
                        n_prev_x = r_cx;
                        n_prev_y = r_cy;
                        n_seg    = r_seg + 1'b1;
                        if (r_seg >= SEG_W'(SEGMENTS - 1)) begin
                            n_line_open = 1'b0;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_line_open  <= 1'b0;
            r_seg        <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_out_valid  <= 1'b0;
            r_div_start  <= 1'b0;
            r_cfg[REG_ROT_X_XT] <= 16'd16384;
            r_cfg[REG_ROT_X_YT] <= 16'd0;
            r_cfg[REG_ROT_Y_XT] <= 16'd0;
            r_cfg[REG_ROT_Y_YT] <= 16'd16384;
            r_cfg[REG_ROT_Z_XT] <= 16'd0;
            r_cfg[REG_ROT_Z_YT] <= 16'd0;
            r_cfg[REG_HW_X]     <= 16'd2731;
            r_cfg[REG_HW_Y]     <= 16'd2731;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_line_open <= n_line_open;
            r_seg       <= n_seg;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_out_valid <= n_out_valid;
            r_div_start <= n_div_start;
            if (psel && penable && pwrite) begin
                r_cfg[paddr[4:2]] <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_start    <= n_start;
        r_m        <= n_m;
        r_lg       <= n_lg;
        r_yt       <= n_yt;
        r_acc      <= n_acc;
        r_px       <= n_px;
        r_py       <= n_py;
        r_pz       <= n_pz;
        r_dv       <= n_dv;
        r_dividend <= n_dividend;
        r_divisor  <= n_divisor;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_v        <= n_v;
        r_r        <= n_r;
        r_neg      <= n_neg;
        r_tx       <= n_tx;
        r_ty       <= n_ty;
        r_ny       <= n_ny;
        r_zl       <= n_zl;
        r_ox       <= n_ox;
        r_oy       <= n_oy;
        r_ocorner  <= n_ocorner;
        r_oseg     <= n_oseg;
        r_olast    <= n_olast;
        r_ozl      <= n_ozl;
    end

    slqe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_dividend),
        .i_divisor  (r_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign o_out_valid   = r_out_valid;
    assign o_vert_x      = r_ox;
    assign o_vert_y      = r_oy;
    assign o_corner      = r_ocorner;
    assign o_segment     = r_oseg;
    assign o_last        = r_olast;
    assign o_zero_length = r_ozl;

`ifndef SYNTHESIS
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken twice in a row");
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_PDIV || r_state == S_ODIV))
        else $error("divider finished outside a wait state");
    a_emit_line_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_line_open)
        else $error("segment emitted with no open line");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: scope line quad expander testbench
// Drives sample beats and register writes, predicts every vertex from its own
// bit-exact model of compression, rotation, projection and quad widening, and
// compares each output beat in order. Random idling and a long receiver
// hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
module tb;
    import slqe_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic [2:0]         corner;
        logic [7:0]         seg;
        logic               last;
        logic               zl;
    } vertex_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic signed [15:0]    i_sample;
    logic                  i_line_start;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic signed [15:0]    o_vert_x;
    logic signed [15:0]    o_vert_y;
    logic [2:0]            o_corner;
    logic [7:0]            o_segment;
    logic                  o_last;
    logic                  o_zero_length;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    scope_line_quad_expander DUT (.*);

    vertex_t     vert_q[$];
    logic [15:0] reg_shadow[CFG_N];
    longint      pt_x, pt_y;
    int          seg_cnt;
    bit          line_on;
    int          err_cnt;
    bit          idle_on;
    int          hold_cnt;
    longint      cyc;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic longint rnd_div(longint num, longint den);
        longint m;
        longint q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint rnd_shr(longint v, int n);
        longint m;
        longint q;
        m = (v < 0) ? -v : v;
        q = (m + (longint'(1) << (n - 1))) >>> n;
        return (v < 0) ? -q : q;
    endfunction

    function automatic longint clip16(longint v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic longint coef(int idx);
        return longint'($signed(reg_shadow[idx]));
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint log_compress(longint s);
        longint unsigned mag;
        longint unsigned m;
        longint unsigned lg;
        mag = (s < 0) ? -s : s;
        m = (3 * mag + 32768) << 15;
        lg = 0;
        while (m >= (64'd1 << 31)) begin
            m = m >> 1;
            lg = lg + (64'd1 << 16);
        end
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                lg = lg | (64'd1 << (15 - i));
            end
        end
        return (s < 0) ? -longint'(lg >> 2) : longint'(lg >> 2);
    endfunction

    task automatic project_point(input longint s, input longint xt,
                                 output longint px, output longint py);
        longint c, cm, yt, x, y, z, den;
        c  = log_compress(s);
        cm = (c < 0) ? -c : c;
        yt = (cm * 13107 + 32768) >>> 16;
        if (c < 0) yt = -yt;
        x = rnd_shr(coef(REG_ROT_X_XT) * xt + coef(REG_ROT_X_YT) * yt, 14);
        y = rnd_shr(coef(REG_ROT_Y_XT) * xt + coef(REG_ROT_Y_YT) * yt, 14);
        z = rnd_shr(coef(REG_ROT_Z_XT) * xt + coef(REG_ROT_Z_YT) * yt, 14);
        den = z + 65536;
        if (den < 1) den = 1;
        px = clip16(rnd_div(x * 32768, 3 * den));
        py = clip16(rnd_div(y * 32768, 3 * den));
    endtask

    task automatic predict_quad(input longint s, input bit start);
        longint cx, cy, dx, dy, tx, ty, nx, ny, l8, hwx, hwy, bx, by, ns, ts;
        vertex_t v;
        bit zl;
        if (start || !line_on) begin
            project_point(s, -16384, pt_x, pt_y);
            seg_cnt = 0;
            line_on = 1'b1;
            return;
        end
        project_point(s, rnd_div((2 * seg_cnt + 2 - SEGMENTS) * 16384, SEGMENTS), cx, cy);
        dx = cx - pt_x;
        dy = cy - pt_y;
        tx = 0; ty = 0; nx = 0; ny = 0;
        hwx = reg_shadow[REG_HW_X];
        hwy = reg_shadow[REG_HW_Y];
        zl = (dx * dx + dy * dy) == 0;
        if (!zl) begin
            l8 = int_sqrt(longint'(dx * dx + dy * dy) << 16);
            tx = rnd_div(dx * hwx * 32, l8);
            ty = rnd_div(dy * hwx * 32, l8);
            nx = -ty;
            ny = rnd_div(dx * hwy * 32, l8);
        end
        for (int i = 0; i < 8; i++) begin
            bx = (i < 4) ? pt_x : cx;
            by = (i < 4) ? pt_y : cy;
            ns = (i % 2) ? 1 : -1;
            ts = (i < 2) ? -1 : ((i >= 6) ? 1 : 0);
            v.vx     = 16'(clip16(bx + ns * nx + ts * tx));
            v.vy     = 16'(clip16(by + ns * ny + ts * ty));
            v.corner = 3'(i);
            v.seg    = 8'(seg_cnt);
            v.last   = (i == 7);
            v.zl     = zl;
            vert_q.push_back(v);
        end
        pt_x = cx;
        pt_y = cy;
        seg_cnt++;
        if (seg_cnt >= SEGMENTS) line_on = 1'b0;
    endtask

    // ---------------- drivers ----------------
    task automatic send_sample(input logic signed [15:0] s, input bit start);
        i_in_valid   <= 1'b1;
        i_sample     <= s;
        i_line_start <= start;
        do @(posedge i_clk); while (!o_in_ready);
        predict_quad(s, start);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (vert_q.size() != 0);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_shadow[idx] = val;
    endtask

    task automatic load_regs(input logic [15:0] xx, xy, yx, yy, zx, zy, hx, hy);
        write_reg(REG_ROT_X_XT, xx);
        write_reg(REG_ROT_X_YT, xy);
        write_reg(REG_ROT_Y_XT, yx);
        write_reg(REG_ROT_Y_YT, yy);
        write_reg(REG_ROT_Z_XT, zx);
        write_reg(REG_ROT_Z_YT, zy);
        write_reg(REG_HW_X, hx);
        write_reg(REG_HW_Y, hy);
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 4))
            0: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            1: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // ---------------- receiver and checker ----------------
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt > 0) begin
                i_out_ready <= 1'b0;
                hold_cnt--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        vertex_t e;
        cyc <= cyc + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (vert_q.size() == 0) begin
                $display("%0t: vertex beat with none expected, x %0d y %0d",
                         $time, o_vert_x, o_vert_y);
                err_cnt++;
            end else begin
                e = vert_q.pop_front();
                if (o_vert_x !== e.vx || o_vert_y !== e.vy || o_corner !== e.corner ||
                    o_segment !== e.seg || o_last !== e.last ||
                    o_zero_length !== e.zl) begin
                    $display("%0t: mismatch exp x %0d y %0d c %0d s %0d l %0d z %0d",
                             $time, e.vx, e.vy, e.corner, e.seg, e.last, e.zl);
                    $display("%0t:          got x %0d y %0d c %0d s %0d l %0d z %0d",
                             $time, o_vert_x, o_vert_y, o_corner, o_segment,
                             o_last, o_zero_length);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cyc >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        send_sample(16'sd0, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sh4000, 1'b1);
        send_sample(-16'sh4000, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        wait_idle();
    endtask

    task automatic test_zero_length();
        load_regs(16'd0, 16'sd16384, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'd2731, 16'd2731);
        send_sample(16'sd1234, 1'b1);
        send_sample(16'sd1234, 1'b0);
        send_sample(16'sd1234, 1'b0);
        send_sample(-16'sd500, 1'b0);
        send_sample(-16'sd500, 1'b0);
        wait_idle();
    endtask

    task automatic test_reg_extremes();
        load_regs(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
                  16'sd16384, 16'sd16384, 16'hffff, 16'hffff);
        for (int i = 0; i < 6; i++) send_sample(pick_sample(), i == 0);
        wait_idle();
        load_regs(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
                  -16'sd16384, -16'sd16384, 16'd0, 16'd0);
        for (int i = 0; i < 6; i++) send_sample(pick_sample(), i == 0);
        wait_idle();
        load_regs(16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384,
                  -16'sd16384, 16'sd16384, 16'hffff, 16'd1);
        for (int i = 0; i < 6; i++) send_sample(pick_sample(), i == 0);
        wait_idle();
    endtask

    task automatic test_full_line();
        load_regs(16'sd16384, 16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'd2731, 16'd2731);
        send_sample(pick_sample(), 1'b1);
        for (int i = 0; i < SEGMENTS; i++) send_sample(pick_sample(), 1'b0);
        send_sample(pick_sample(), 1'b0);
        send_sample(pick_sample(), 1'b0);
        wait_idle();
    endtask

    task automatic test_random();
        load_regs(16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                  16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                  16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                  16'($urandom), 16'($urandom));
        hold_cnt = 2000;
        for (int i = 0; i < 160; i++) send_sample(pick_sample(), $urandom_range(0, 19) == 0);
        wait_idle();
    endtask

    task automatic test_quiet_tail();
        idle_on = 1'b0;
        load_regs(16'sd11585, -16'sd11585, 16'sd11585, 16'sd11585,
                  16'sd8000, -16'sd9000, 16'd4000, 16'd1500);
        for (int i = 0; i < 20; i++) send_sample(pick_sample(), i == 0);
        wait_idle();
    endtask

    initial begin
        cyc = 0;
        err_cnt = 0;
        hold_cnt = 0;
        idle_on = 1'b1;
        line_on = 1'b0;
        seg_cnt = 0;
        pt_x = 0;
        pt_y = 0;
        reg_shadow = '{16'sd16384, 16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'd2731, 16'd2731};
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_sample     <= '0;
        i_line_start <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_zero_length();
        test_reg_extremes();
        test_full_line();
        test_random();
        test_quiet_tail();

        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
